[rtl/matting_alpha_projection_assert.svh]
// Assertion macros shared by the alpha projection RTL.
`ifndef MATTING_ALPHA_PROJECTION_ASSERT_SVH
`define MATTING_ALPHA_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define MAP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MAP_ASSERT_CLK(lbl, prop, msg) `MAP_ASSERT(lbl, clock, reset, prop, msg)
`else
`define MAP_ASSERT(lbl, clk, rst, prop, msg)
`define MAP_ASSERT_CLK(lbl, prop, msg)
`endif
`endif

[rtl/map_pkg.sv]
// Widths, constants and pipeline control type for the alpha projection block.
package map_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int COLOUR_W     = 24;
   localparam int DIFF_W       = CHANNEL_BITS + 1;
   localparam int PROD_W       = 2 * CHANNEL_BITS + 2;
   localparam int DOT_W        = 2 * CHANNEL_BITS + 3;
   localparam int LEN_W        = 2 * CHANNEL_BITS + 2;
   localparam int ALPHA_W      = 8;
   localparam int NUM_W        = LEN_W + ALPHA_W;

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;
   localparam logic [ALPHA_W-1:0] ALPHA_NONE = 8'd0;

   typedef struct packed {
      logic               valid;
      logic               bypass;
      logic               degenerate;
      logic [ALPHA_W-1:0] alpha;
   } map_ctl_type;

endpackage

[rtl/map_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`include "matting_alpha_projection_assert.svh"

module map_div
   import map_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  map_ctl_type        in_ctl,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [LEN_W-1:0]   in_len,
   output map_ctl_type        out_ctl,
   output logic [ALPHA_W-1:0] out_alpha
);

   map_ctl_type        ctl_ff [ALPHA_W];
   logic [NUM_W-1:0]   rem_ff [ALPHA_W];
   logic [LEN_W-1:0]   div_ff [ALPHA_W];
   logic [ALPHA_W-1:0] q_ff   [ALPHA_W];

   map_ctl_type        ctl_in [ALPHA_W];
   logic [NUM_W-1:0]   rem_in [ALPHA_W];
   logic [LEN_W-1:0]   div_in [ALPHA_W];
   logic [ALPHA_W-1:0] q_in   [ALPHA_W];

   // stage j resolves quotient bit ALPHA_W-1-j
   always_comb begin
      logic [NUM_W-1:0]   src_rem;
      logic [LEN_W-1:0]   src_div;
      logic [ALPHA_W-1:0] src_q;
      logic [NUM_W-1:0]   trial;
      for (int j = 0; j < ALPHA_W; j++) begin
         if (j == 0) begin
            ctl_in[j] = in_ctl;
            src_rem   = in_num;
            src_div   = in_len;
            src_q     = '0;
         end else begin
            ctl_in[j] = ctl_ff[j-1];
            src_rem   = rem_ff[j-1];
            src_div   = div_ff[j-1];
            src_q     = q_ff[j-1];
         end
         trial     = NUM_W'(src_div) << (ALPHA_W - 1 - j);
         div_in[j] = src_div;
         q_in[j]   = src_q;
         if (src_rem >= trial) begin
            rem_in[j]                  = src_rem - trial;
            q_in[j][ALPHA_W - 1 - j]   = 1'b1;
         end else begin
            rem_in[j] = src_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ALPHA_W; j++) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (en) begin
            ctl_ff[j] <= ctl_in[j];
         end
         if (en) begin
            rem_ff[j] <= rem_in[j];
            div_ff[j] <= div_in[j];
            q_ff[j]   <= q_in[j];
         end
      end
   end

   assign out_ctl   = ctl_ff[ALPHA_W-1];
   assign out_alpha = out_ctl.bypass ? out_ctl.alpha : q_ff[ALPHA_W-1];

   `MAP_ASSERT_CLK(a_div_advance,
      en |=> ctl_ff[ALPHA_W-1].valid == $past(ctl_ff[ALPHA_W-2].valid),
      "divider valid bit lost or invented on advance")
   `MAP_ASSERT_CLK(a_div_rem,
      out_ctl.valid && !out_ctl.bypass |-> rem_ff[ALPHA_W-1] < NUM_W'(div_ff[ALPHA_W-1]),
      "final remainder not below divisor")
   `MAP_ASSERT_CLK(a_div_hold,
      !en |=> $stable(q_ff[ALPHA_W-1]) && $stable(ctl_ff[ALPHA_W-1]),
      "divider output moved while held")

endmodule

[rtl/matting_alpha_projection.sv]
// Top level of the knockout-style alpha projection pipeline.
//
// Usage: every req_ transaction carries a foreground sample, a background
// sample and an observed pixel, each packed red/green/blue (red on top).
// Each one yields exactly one rsp_ transaction with an 8-bit alpha and a
// degenerate flag, in arrival order.
// alpha = floor(255 * dot / len2) clamped to 0..255, where dot is
// (pixel - bg).(fg - bg) and len2 is |fg - bg|^2. Equal samples give alpha
// 255 with degenerate set.
// Pipeline: 12 register stages: four for differences, products, sums and
// classification, then eight divider stages, one quotient bit each.
// rsp_valid is the valid bit of the last divider stage. Throughput: one
// transaction per cycle while no valid result is held under rsp_stall.
// Stalls: the whole pipeline freezes while rsp_valid is held under
// rsp_stall; req_stall follows it in the same cycle. Bubbles flow freely.
// Reset clears every valid bit and holds req_stall; no result is shown
// until new input arrives.
`include "matting_alpha_projection_assert.svh"

module matting_alpha_projection
   import map_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COLOUR_W-1:0] req_fg_colour,
   input  logic [COLOUR_W-1:0] req_bg_colour,
   input  logic [COLOUR_W-1:0] req_pixel_colour,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ALPHA_W-1:0]  rsp_alpha,
   output logic                rsp_degenerate
);

   // global advance: pipeline only holds when the output is blocked
   logic        adv;
   map_ctl_type out_ctl;

   assign rsp_valid      = out_ctl.valid;
   assign rsp_degenerate = out_ctl.degenerate;
   assign adv            = !(rsp_valid && rsp_stall);
   assign req_stall      = reset || !adv;

   // stage 1: signed channel differences
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s_ff [NUM_CHANNELS];
   logic signed [DIFF_W-1:0] d_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            s_ff[i] <= signed'({1'b0, req_fg_colour[i*CHANNEL_BITS +: CHANNEL_BITS]})
                     - signed'({1'b0, req_bg_colour[i*CHANNEL_BITS +: CHANNEL_BITS]});
            d_ff[i] <= signed'({1'b0, req_pixel_colour[i*CHANNEL_BITS +: CHANNEL_BITS]})
                     - signed'({1'b0, req_bg_colour[i*CHANNEL_BITS +: CHANNEL_BITS]});
         end
      end
   end

   // stage 2: per-channel products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] dp_ff [NUM_CHANNELS];
   logic signed [PROD_W-1:0] sq_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            dp_ff[i] <= PROD_W'(d_ff[i] * s_ff[i]);
            sq_ff[i] <= PROD_W'(s_ff[i] * s_ff[i]);
         end
      end
   end

   // stage 3: dot product and squared length
   logic                    s3_valid_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic [LEN_W-1:0]        len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         dot_ff <= DOT_W'(dp_ff[0]) + DOT_W'(dp_ff[1]) + DOT_W'(dp_ff[2]);
         len_ff <= LEN_W'(sq_ff[0]) + LEN_W'(sq_ff[1]) + LEN_W'(sq_ff[2]);
      end
   end

   // stage 4: classify special cases, build 255*dot for the divider
   map_ctl_type      ctl4_in;
   map_ctl_type      ctl4_ff;
   logic [NUM_W-1:0] num4_in;
   logic [NUM_W-1:0] num4_ff;
   logic [LEN_W-1:0] len4_ff;
   logic [LEN_W-1:0] dot_mag;

   always_comb begin
      ctl4_in.valid      = s3_valid_ff;
      ctl4_in.bypass     = 1'b1;
      ctl4_in.degenerate = 1'b0;
      ctl4_in.alpha      = ALPHA_FULL;
      if (len_ff == '0) begin
         ctl4_in.degenerate = 1'b1;
      end else if (dot_ff <= 0) begin
         ctl4_in.alpha = ALPHA_NONE;
      end else if (dot_ff >= signed'({1'b0, len_ff})) begin
         ctl4_in.alpha = ALPHA_FULL;
      end else begin
         ctl4_in.bypass = 1'b0;
      end
   end

   // only used when 0 < dot < len2, so the magnitude fits LEN_W bits
   assign dot_mag = LEN_W'(dot_ff);
   assign num4_in = (NUM_W'(dot_mag) << ALPHA_W) - NUM_W'(dot_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl4_ff <= ctl4_in;
      end
      if (adv) begin
         num4_ff <= num4_in;
         len4_ff <= len_ff;
      end
   end

   // stages 5 to 12: quotient bits, last stage is the output register
   map_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_ctl    (ctl4_ff),
      .in_num    (num4_ff),
      .in_len    (len4_ff),
      .out_ctl   (out_ctl),
      .out_alpha (rsp_alpha)
   );

   `MAP_ASSERT_CLK(a_degen_full,
      rsp_valid && rsp_degenerate |-> rsp_alpha == ALPHA_FULL,
      "degenerate result without full alpha")
   `MAP_ASSERT_CLK(a_s2_advance,
      adv |=> s2_valid_ff == $past(s1_valid_ff),
      "stage 2 valid bit lost or invented")
   `MAP_ASSERT_CLK(a_s4_degen,
      ctl4_ff.valid && ctl4_ff.degenerate |-> ctl4_ff.bypass && len4_ff == '0,
      "degenerate flag without zero length")

endmodule

[verif/matting_alpha_projection_tb.sv]
// Self-checking testbench for the matting alpha projection pipeline.
module matting_alpha_projection_tb;
   import map_pkg::*;

   typedef logic [COLOUR_W-1:0] colour_type;
   typedef logic [ALPHA_W-1:0]  alpha_type;

   // One expected rsp_ transaction.
   typedef struct packed {
      alpha_type alpha;
      logic      degenerate;
   } matte_type;

   // Receiver stall styles.
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_type;

   localparam int LONG_HOLD    = 150;   // cycles of the long receiver hold-off
   localparam int DRAIN_CYCLES = 30;    // settle time after the last result (12 stages)
   localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

   // ------------------------------------------------------------------
   // Clock, reset and block inputs; every input is known from time zero.
   // ------------------------------------------------------------------
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   colour_type req_fg_colour    = '0;
   colour_type req_bg_colour    = '0;
   colour_type req_pixel_colour = '0;
   logic       rsp_stall        = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   alpha_type  rsp_alpha;
   logic       rsp_degenerate;

   always #5 clock = ~clock;

   matting_alpha_projection dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_fg_colour    (req_fg_colour),
      .req_bg_colour    (req_bg_colour),
      .req_pixel_colour (req_pixel_colour),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_alpha        (rsp_alpha),
      .rsp_degenerate   (rsp_degenerate)
   );

   // ------------------------------------------------------------------
   // Shared state between the test sequence, the sender pacing, the
   // receiver stall generator and the scoreboard.
   // ------------------------------------------------------------------
   matte_type       expected_mattes[$];   // predictions in arrival order
   int              mismatch_count  = 0;
   int              items_sent      = 0;
   int              results_checked = 0;
   int              degenerate_seen = 0;
   int              clamped_low     = 0;
   int              saturated_high  = 0;
   int              interior_alphas = 0;

   int              max_gap     = 0;      // sender gap bound, 0 streams back to back
   int              burst_left  = 0;
   stall_style_type stall_style = STALL_NONE;
   int              hold_requests = 0;    // bumped to ask the receiver for a long hold-off

   // ------------------------------------------------------------------
   // Predictor: projects the pixel onto the bg->fg line.
   //   s = fg - bg, d = pixel - bg, per channel, signed
   //   alpha = floor(255 * d.s / s.s), clamped; s.s == 0 flags degenerate
   // Channel values stay small, so longint holds 255 * dot with room.
   // ------------------------------------------------------------------
   function automatic matte_type project_alpha(colour_type fg, colour_type bg,
                                               colour_type px);
      longint    dot;
      longint    len2;
      longint    s;
      longint    d;
      matte_type m;
      dot  = 0;
      len2 = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s = longint'(fg[c*CHANNEL_BITS +: CHANNEL_BITS])
           - longint'(bg[c*CHANNEL_BITS +: CHANNEL_BITS]);
         d = longint'(px[c*CHANNEL_BITS +: CHANNEL_BITS])
           - longint'(bg[c*CHANNEL_BITS +: CHANNEL_BITS]);
         dot  += d * s;
         len2 += s * s;
      end
      m.degenerate = 1'b0;
      if (len2 == 0) begin
         // equal samples: no line to project onto
         m.alpha      = ALPHA_FULL;
         m.degenerate = 1'b1;
      end else if (dot <= 0) begin
         m.alpha = ALPHA_NONE;         // on or behind the background side
      end else if (dot >= len2) begin
         m.alpha = ALPHA_FULL;         // at or past the foreground sample
      end else begin
         m.alpha = alpha_type'((dot * longint'(ALPHA_FULL)) / len2);
      end
      return m;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Scoreboard. Samples both handshakes at the rising edge, where the
   // values seen are the ones settled before the edge. A req_ transaction
   // queues its prediction; an rsp_ transaction takes the oldest one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      matte_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_mattes.insert(expected_mattes.size(),
                                   project_alpha(req_fg_colour, req_bg_colour,
                                                 req_pixel_colour));
         if (rsp_valid && !rsp_stall) begin
            if (expected_mattes.size() == 0) begin
               report_mismatch("result with nothing pending, alpha",
                               int'(rsp_alpha), -1);
            end else begin
               want = expected_mattes.pop_front();
               results_checked++;
               if (rsp_alpha !== want.alpha)
                  report_mismatch("alpha", int'(rsp_alpha), int'(want.alpha));
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", int'(rsp_degenerate),
                                  int'(want.degenerate));
               if (want.degenerate)              degenerate_seen++;
               else if (want.alpha == ALPHA_NONE) clamped_low++;
               else if (want.alpha == ALPHA_FULL) saturated_high++;
               else                               interior_alphas++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver. A requested hold-off is counted here, cycle by cycle;
   // otherwise rsp_stall follows the current style. One assignment per edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      static int   hold_left   = 0;
      static int   holds_taken = 0;
      static int   run_left    = 0;
      static logic run_state   = 1'b0;
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               // alternating runs of stall and flow with random lengths
               if (run_left == 0) begin
                  run_state = ~run_state;
                  run_left  = run_state ? $urandom_range(1, 8) : $urandom_range(1, 12);
               end
               run_left--;
               rsp_stall <= run_state;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sender. Drives one transaction and waits for it to be taken. Between
   // bursts valid drops for a random gap; valid stays up inside a burst so
   // consecutive items never lower and raise it in the same step.
   // ------------------------------------------------------------------
   task automatic send_pixel(colour_type fg, colour_type bg, colour_type px);
      int gap;
      req_valid        <= 1'b1;
      req_fg_colour    <= fg;
      req_bg_colour    <= bg;
      req_pixel_colour <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (max_gap > 0) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, max_gap);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Sender goes quiet until every predicted result has been checked.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_mattes.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_channel();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return CHAN_MAX;
         default: return $urandom_range(0, CHAN_MAX);
      endcase
   endfunction

   function automatic colour_type random_colour();
      colour_type c;
      for (int k = 0; k < NUM_CHANNELS; k++)
         c[k*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(pick_channel());
      return c;
   endfunction

   // Pixel placed near bg + t/256 * (fg - bg), with a little noise, so most
   // random transactions land on interior alphas rather than the clamps.
   function automatic colour_type colour_on_line(colour_type fg, colour_type bg);
      colour_type px;
      int         t;
      int         f;
      int         b;
      int         v;
      t = $urandom_range(0, 280);
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         f = int'(fg[k*CHANNEL_BITS +: CHANNEL_BITS]);
         b = int'(bg[k*CHANNEL_BITS +: CHANNEL_BITS]);
         v = b + ((f - b) * t) / 256 + int'($urandom_range(0, 6)) - 3;
         if (v < 0)        v = 0;
         if (v > CHAN_MAX) v = CHAN_MAX;
         px[k*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(v);
      end
      return px;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner colours: clamps, degenerate samples, exact hits on either end,
   // orthogonal offsets, reversed sample order and alternating bit patterns.
   task automatic test_directed_corners();
      max_gap     = 0;
      stall_style <= STALL_NONE;
      send_pixel(24'h000000, 24'h000000, 24'h000000);   // equal samples, all zero
      send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'h123456);   // equal samples, all ones
      send_pixel(24'hFFFFFF, 24'h000000, 24'hFFFFFF);   // pixel on foreground
      send_pixel(24'hFFFFFF, 24'h000000, 24'h000000);   // pixel on background
      send_pixel(24'hFFFFFF, 24'h000000, 24'h808080);   // halfway
      send_pixel(24'h808080, 24'h000000, 24'hFFFFFF);   // beyond foreground
      send_pixel(24'hFFFFFF, 24'h808080, 24'h000000);   // behind background
      send_pixel(24'hFF0000, 24'h000000, 24'h00FF00);   // orthogonal, dot zero
      send_pixel(24'h0000FF, 24'h000000, 24'h0000FF);   // dot equals len2
      send_pixel(24'h0000FF, 24'h000000, 24'h0000FE);   // one short of full
      send_pixel(24'h000000, 24'hFFFFFF, 24'h808080);   // fg below bg
      send_pixel(24'h000000, 24'hFFFFFF, 24'h000000);   // fg below bg, on fg
      send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
      send_pixel(24'h555555, 24'hAAAAAA, 24'h5A5A5A);
      send_pixel(24'h00FF00, 24'h000000, 24'h000100);   // smallest positive dot for these samples
      send_pixel(24'hFF00FF, 24'h00FF00, 24'h7F807F);
      send_pixel(24'h010000, 24'h000000, 24'h000001);   // unit len2, orthogonal
      send_pixel(24'h000001, 24'h000000, 24'hFFFFFF);   // unit len2, far beyond
      wait_results_drained();
   endtask

   // Mostly on-line pixels with random samples; the rest are fully random,
   // equal-sample or end-point cases. Input bursts and output stalls vary.
   task automatic test_random_mix(int count);
      colour_type fg;
      colour_type bg;
      colour_type px;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            max_gap     = (n % 200 == 0) ? 5 : 0;   // some stretches with no gaps
            stall_style <= stall_style_type'($urandom_range(0, 2));
         end
         fg = random_colour();
         bg = random_colour();
         case ($urandom_range(0, 9))
            0:       px = COLOUR_W'($urandom());
            1: begin
               bg = fg;
               px = random_colour();
            end
            2:       px = $urandom_range(0, 1) ? fg : bg;
            default: px = colour_on_line(fg, bg);
         endcase
         if ($urandom_range(0, 5) == 0) fg = COLOUR_W'($urandom());
         send_pixel(fg, bg, px);
      end
      wait_results_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // back to back, so the pipeline fills and req_stall has to assert.
   task automatic test_output_hold_off();
      max_gap     = 0;
      stall_style <= STALL_NONE;
      hold_requests++;
      for (int n = 0; n < 40; n++) begin
         colour_type fg;
         colour_type bg;
         fg = random_colour();
         bg = random_colour();
         send_pixel(fg, bg, colour_on_line(fg, bg));
      end
      // sender pauses here until every outstanding result is back
      wait_results_drained();
   endtask

   // Full rate in both directions.
   task automatic test_full_rate_stream();
      max_gap     = 0;
      stall_style <= STALL_NONE;
      for (int n = 0; n < 40; n++) begin
         colour_type fg;
         colour_type bg;
         fg = random_colour();
         bg = random_colour();
         send_pixel(fg, bg, colour_on_line(fg, bg));
      end
      wait_results_drained();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_mix(420);
      test_output_hold_off();
      test_full_rate_stream();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions, checked %0d results: %0d degenerate, %0d at zero,",
               items_sent, results_checked, degenerate_seen, clamped_low);
      $display("%0d saturated, %0d interior; bursty input, varied output stalls, long hold-off.",
               saturated_high, interior_alphas);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legitimate run.
   initial begin
      #3000000;
      $display("Timeout with %0d results still pending", expected_mattes.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
